>>> rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int ID_W      = 16;
  localparam int REQ_W     = 11;
  localparam int BLK_OUT_W = 7;
  localparam int AMT_W     = 11;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    ST_ALLOCATED  = 3'd0,
    ST_NO_FIT     = 3'd1,
    ST_RELEASED   = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    FOP_HOLD,
    FOP_REMOVE,
    FOP_INSERT
  } free_op_t;

  typedef enum logic [1:0] {
    AOP_HOLD,
    AOP_PUSH,
    AOP_REMOVE
  } alloc_op_t;

  // left-to-right chain through the free list
  typedef struct packed {
    logic seen;  // a fitting piece sits at or left of this point
    logic pass;  // every cell so far is ahead of the insert position
  } free_chain_t;

endpackage

>>> rtl/core/bfa_free_cell.sv
`timescale 1ns / 1ps
module bfa_free_cell #(
  parameter int PW = 11,
  parameter int BW = 7,
  parameter bit FIRST = 1'b0,
  parameter bit INIT_VALID = 1'b0,
  parameter logic [PW-1:0] INIT_SIZE = '0,
  parameter logic [BW-1:0] INIT_BLK = '0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfa_pkg::free_op_t    op,
  input  logic [PW-1:0]        key_size,
  input  logic [BW-1:0]        key_blk,
  input  logic                 l_valid,
  input  logic [PW-1:0]        l_size,
  input  logic [BW-1:0]        l_blk,
  input  logic                 r_valid,
  input  logic [PW-1:0]        r_size,
  input  logic [BW-1:0]        r_blk,
  input  bfa_pkg::free_chain_t chain_in,
  output bfa_pkg::free_chain_t chain_out,
  output logic                 pick,
  output logic                 valid,
  output logic [PW-1:0]        size,
  output logic [BW-1:0]        blk
);

  logic          valid_r, valid_nxt;
  logic [PW-1:0] size_r, size_nxt;
  logic [BW-1:0] blk_r, blk_nxt;
  logic          hit, pass;

  assign hit  = valid_r && (size_r >= key_size);
  // an equal-size piece goes behind the head
  assign pass = valid_r && (FIRST ? (size_r <= key_size) : (size_r < key_size));

  assign chain_out.seen = chain_in.seen | hit;
  assign chain_out.pass = chain_in.pass & pass;
  assign pick = hit & ~chain_in.seen;

  always_comb begin
    valid_nxt = valid_r;
    size_nxt  = size_r;
    blk_nxt   = blk_r;
    unique case (op)
      bfa_pkg::FOP_REMOVE: begin
        if (chain_in.seen || hit) begin
          valid_nxt = r_valid;
          size_nxt  = r_size;
          blk_nxt   = r_blk;
        end
      end
      bfa_pkg::FOP_INSERT: begin
        if (!chain_in.pass) begin
          valid_nxt = l_valid;
          size_nxt  = l_size;
          blk_nxt   = l_blk;
        end else if (!pass) begin
          valid_nxt = 1'b1;
          size_nxt  = key_size;
          blk_nxt   = key_blk;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= INIT_VALID;
      size_r  <= INIT_VALID ? INIT_SIZE : '0;
      blk_r   <= INIT_VALID ? INIT_BLK : '0;
    end else begin
      valid_r <= valid_nxt;
      size_r  <= size_nxt;
      blk_r   <= blk_nxt;
    end
  end

  assign valid = valid_r;
  assign size  = size_r;
  assign blk   = blk_r;

endmodule

>>> rtl/core/bfa_alloc_cell.sv
`timescale 1ns / 1ps
module bfa_alloc_cell #(
  parameter int BW = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfa_pkg::alloc_op_t          op,
  input  logic [bfa_pkg::ID_W-1:0]    key_tag,
  input  logic [BW-1:0]               key_blk,
  input  logic [bfa_pkg::REQ_W-1:0]   key_bytes,
  input  logic                        l_valid,
  input  logic                        r_valid,
  input  logic [bfa_pkg::ID_W-1:0]    r_tag,
  input  logic [BW-1:0]               r_blk,
  input  logic [bfa_pkg::REQ_W-1:0]   r_bytes,
  input  logic                        seen_in,
  input  logic                        later_in,
  output logic                        seen_out,
  output logic                        later_out,
  output logic                        sel,
  output logic                        valid,
  output logic [bfa_pkg::ID_W-1:0]    tag,
  output logic [BW-1:0]               blk,
  output logic [bfa_pkg::REQ_W-1:0]   bytes
);

  logic                      valid_r, valid_nxt;
  logic [bfa_pkg::ID_W-1:0]  tag_r, tag_nxt;
  logic [BW-1:0]             blk_r, blk_nxt;
  logic [bfa_pkg::REQ_W-1:0] bytes_r, bytes_nxt;
  logic                      match;

  assign match     = valid_r && (tag_r == key_tag);
  // newest match wins: nothing matching further right
  assign sel       = match & ~later_in;
  assign later_out = later_in | match;
  assign seen_out  = seen_in | sel;

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    blk_nxt   = blk_r;
    bytes_nxt = bytes_r;
    unique case (op)
      bfa_pkg::AOP_PUSH: begin
        if (l_valid && !valid_r) begin
          valid_nxt = 1'b1;
          tag_nxt   = key_tag;
          blk_nxt   = key_blk;
          bytes_nxt = key_bytes;
        end
      end
      bfa_pkg::AOP_REMOVE: begin
        if (seen_in || sel) begin
          valid_nxt = r_valid;
          tag_nxt   = r_tag;
          blk_nxt   = r_blk;
          bytes_nxt = r_bytes;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= tag_nxt;
    blk_r   <= blk_nxt;
    bytes_r <= bytes_nxt;
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign blk   = blk_r;
  assign bytes = bytes_r;

endmodule

>>> rtl/core/best_fit_block_allocator.sv
`timescale 1ns / 1ps
// Best-fit block allocator built as two cell chains: a size-ordered free list
// of NUM_BLOCKS+ALLOC_DEPTH cells and an allocation table of ALLOC_DEPTH cells.
// Input channel in_*: in_tuser is the mode (0 allocate, 1 release), in_tdata
// holds request_id and req_size. One result per request on out_*: out_tuser
// is the status, out_tdata holds block_num and amount.
// Each request runs a search/remove pass over the chains, then an optional
// insert pass into the free list, then the result is loaded into the output
// register; in_tready returns in the same cycle as the result appears.
// The output register holds a result while out_tready is low; a new request
// is still accepted and runs up to its final step, where it waits for the
// register to empty.
// After reset the free list holds every block at full size in id order and
// the table is empty; the block is ready in the first cycle after reset.
module best_fit_block_allocator #(
  parameter int NUM_BLOCKS  = 64,
  parameter int BLOCK_BYTES = 1024,
  parameter int ALLOC_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bfa_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] request_id, [26:16] req_size
  input  logic                           in_tuser,   // [0] mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bfa_pkg::OUT_DATA_W-1:0] out_tdata,  // [6:0] block_num, [17:7] amount
  output logic [2:0]                     out_tuser   // [2:0] status
);

  localparam int FCAP = NUM_BLOCKS + ALLOC_DEPTH;
  localparam int BW = $clog2(NUM_BLOCKS + 1);
  localparam int BB_W = $clog2(BLOCK_BYTES + 1);
  localparam int PW = (BB_W > bfa_pkg::REQ_W) ? BB_W : bfa_pkg::REQ_W;

  typedef enum logic [1:0] {S_IDLE, S_FIND, S_INS, S_DONE} state_t;

  state_t                       state_r;
  bfa_pkg::mode_t               mode_r;
  logic [bfa_pkg::ID_W-1:0]     id_r;
  logic [bfa_pkg::REQ_W-1:0]    req_r;
  logic [PW-1:0]                ins_size_r;
  logic [BW-1:0]                ins_blk_r;
  bfa_pkg::status_t             res_status_r;
  logic [BW-1:0]                res_blk_r;
  logic [bfa_pkg::REQ_W-1:0]    res_amt_r;
  logic                         out_valid_r;
  bfa_pkg::status_t             out_status_r;
  logic [bfa_pkg::BLK_OUT_W-1:0] out_blk_r;
  logic [bfa_pkg::AMT_W-1:0]    out_amt_r;

  bfa_pkg::free_op_t  fop;
  bfa_pkg::alloc_op_t aop;
  logic [PW-1:0]      fkey_size;
  logic [BW-1:0]      fkey_blk;

  logic [FCAP-1:0]          f_valid, f_pick;
  logic [PW-1:0]            f_size [FCAP];
  logic [BW-1:0]            f_blk  [FCAP];
  bfa_pkg::free_chain_t     f_chain [FCAP+1];

  logic [ALLOC_DEPTH-1:0]      a_valid, a_sel;
  logic [BW-1:0]               a_blk   [ALLOC_DEPTH];
  logic [bfa_pkg::REQ_W-1:0]   a_bytes [ALLOC_DEPTH];
  logic [bfa_pkg::ID_W-1:0]    a_tag_w [ALLOC_DEPTH];
  logic [ALLOC_DEPTH:0]        a_seen, a_later;

  logic [PW-1:0]             pick_size;
  logic [BW-1:0]             pick_blk;
  logic [BW-1:0]             sel_blk;
  logic [bfa_pkg::REQ_W-1:0] sel_bytes;
  logic [PW-1:0]             req_ext;
  logic                      out_free;

  assign in_tready = (state_r == S_IDLE);
  assign req_ext   = PW'(req_r);
  assign out_free  = !out_valid_r || out_tready;

  assign fkey_size = (state_r == S_INS) ? ins_size_r : req_ext;
  assign fkey_blk  = ins_blk_r;

  assign f_chain[0] = '{seen: 1'b0, pass: 1'b1};
  assign a_seen[0] = 1'b0;
  assign a_later[ALLOC_DEPTH] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < FCAP; g++) begin : g_free
      bfa_free_cell #(
        .PW(PW), .BW(BW), .FIRST(g == 0),
        .INIT_VALID(g < NUM_BLOCKS),
        .INIT_SIZE(PW'(BLOCK_BYTES)),
        .INIT_BLK(BW'(g + 1))
      ) u_cell (
        .clk(clk), .rst_n(rst_n), .op(fop),
        .key_size(fkey_size), .key_blk(fkey_blk),
        .l_valid((g == 0) ? 1'b0 : f_valid[(g == 0) ? 0 : g - 1]),
        .l_size((g == 0) ? '0 : f_size[(g == 0) ? 0 : g - 1]),
        .l_blk((g == 0) ? '0 : f_blk[(g == 0) ? 0 : g - 1]),
        .r_valid((g == FCAP - 1) ? 1'b0 : f_valid[(g == FCAP - 1) ? g : g + 1]),
        .r_size((g == FCAP - 1) ? '0 : f_size[(g == FCAP - 1) ? g : g + 1]),
        .r_blk((g == FCAP - 1) ? '0 : f_blk[(g == FCAP - 1) ? g : g + 1]),
        .chain_in(f_chain[g]), .chain_out(f_chain[g + 1]),
        .pick(f_pick[g]), .valid(f_valid[g]), .size(f_size[g]), .blk(f_blk[g])
      );
    end

    for (g = 0; g < ALLOC_DEPTH; g++) begin : g_alloc
      bfa_alloc_cell #(.BW(BW)) u_cell (
        .clk(clk), .rst_n(rst_n), .op(aop),
        .key_tag(id_r), .key_blk(pick_blk), .key_bytes(req_r),
        .l_valid((g == 0) ? 1'b1 : a_valid[(g == 0) ? 0 : g - 1]),
        .r_valid((g == ALLOC_DEPTH - 1) ? 1'b0
                 : a_valid[(g == ALLOC_DEPTH - 1) ? g : g + 1]),
        .r_tag((g == ALLOC_DEPTH - 1) ? '0
               : a_tag_w[(g == ALLOC_DEPTH - 1) ? g : g + 1]),
        .r_blk((g == ALLOC_DEPTH - 1) ? '0
               : a_blk[(g == ALLOC_DEPTH - 1) ? g : g + 1]),
        .r_bytes((g == ALLOC_DEPTH - 1) ? '0
                 : a_bytes[(g == ALLOC_DEPTH - 1) ? g : g + 1]),
        .seen_in(a_seen[g]), .later_in(a_later[g + 1]),
        .seen_out(a_seen[g + 1]), .later_out(a_later[g]),
        .sel(a_sel[g]), .valid(a_valid[g]), .tag(a_tag_w[g]),
        .blk(a_blk[g]), .bytes(a_bytes[g])
      );
    end
  endgenerate

  // one-hot selects, so an OR gathers the chosen entry
  always_comb begin
    pick_size = '0;
    pick_blk  = '0;
    for (int i = 0; i < FCAP; i++) begin
      pick_size |= f_pick[i] ? f_size[i] : '0;
      pick_blk  |= f_pick[i] ? f_blk[i] : '0;
    end
  end

  always_comb begin
    sel_blk   = '0;
    sel_bytes = '0;
    for (int i = 0; i < ALLOC_DEPTH; i++) begin
      sel_blk   |= a_sel[i] ? a_blk[i] : '0;
      sel_bytes |= a_sel[i] ? a_bytes[i] : '0;
    end
  end

  always_comb begin
    fop = bfa_pkg::FOP_HOLD;
    aop = bfa_pkg::AOP_HOLD;
    unique case (state_r)
      S_FIND: begin
        if (mode_r == bfa_pkg::MODE_ALLOC) begin
          if (!a_valid[ALLOC_DEPTH-1] && f_chain[FCAP].seen) begin
            fop = bfa_pkg::FOP_REMOVE;
            aop = bfa_pkg::AOP_PUSH;
          end
        end else if (a_later[0]) begin
          aop = bfa_pkg::AOP_REMOVE;
        end
      end
      S_INS: begin
        if (!f_valid[FCAP-1]) fop = bfa_pkg::FOP_INSERT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // the final step reloads the register itself
      if (out_valid_r && out_tready && (state_r != S_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r  <= bfa_pkg::mode_t'(in_tuser);
            id_r    <= in_tdata[15:0];
            req_r   <= in_tdata[26:16];
            state_r <= S_FIND;
          end
        end
        S_FIND: begin
          if (mode_r == bfa_pkg::MODE_ALLOC) begin
            if (a_valid[ALLOC_DEPTH-1]) begin
              res_status_r <= bfa_pkg::ST_TABLE_FULL;
              res_blk_r    <= '0;
              res_amt_r    <= '0;
              state_r      <= S_DONE;
            end else if (!f_chain[FCAP].seen) begin
              res_status_r <= bfa_pkg::ST_NO_FIT;
              res_blk_r    <= '0;
              res_amt_r    <= '0;
              state_r      <= S_DONE;
            end else begin
              res_status_r <= bfa_pkg::ST_ALLOCATED;
              res_blk_r    <= pick_blk;
              res_amt_r    <= req_r;
              ins_size_r   <= pick_size - req_ext;
              ins_blk_r    <= pick_blk;
              state_r      <= (pick_size > req_ext) ? S_INS : S_DONE;
            end
          end else begin
            if (!a_later[0]) begin
              res_status_r <= bfa_pkg::ST_NOT_FOUND;
              res_blk_r    <= '0;
              res_amt_r    <= '0;
              state_r      <= S_DONE;
            end else begin
              res_status_r <= bfa_pkg::ST_RELEASED;
              res_blk_r    <= sel_blk;
              res_amt_r    <= sel_bytes;
              ins_size_r   <= PW'(sel_bytes);
              ins_blk_r    <= sel_blk;
              state_r      <= S_INS;
            end
          end
        end
        S_INS: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_blk_r    <= bfa_pkg::BLK_OUT_W'(res_blk_r);
            out_amt_r    <= res_amt_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_amt_r, out_blk_r};

  // a request is taken only in idle, so the next cycle is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while busy");

  a_free_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((f_valid >> 1) & ~f_valid) == '0)
    else $error("free list has a hole");

  a_table_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((a_valid >> 1) & ~a_valid) == '0)
    else $error("allocation table has a hole");

  a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(f_pick) && $onehot0(a_sel))
    else $error("more than one cell selected");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> out_valid_r)
    else $error("result not loaded");

endmodule
